// File: rtl/kwlex_pkg.sv
package kwlex_pkg;

  localparam int PosBitsDef = 16;
  localparam int OutPosW    = 16;
  localparam int NumW       = 31;
  localparam int FracW      = 5;
  localparam int PrefixW    = 40;
  localparam logic [NumW-1:0]  NumMax  = {NumW{1'b1}};
  localparam logic [FracW-1:0] FracMax = {FracW{1'b1}};

  typedef enum logic [4:0] {
    K_PLUS   = 5'd0,
    K_MINUS  = 5'd1,
    K_STAR   = 5'd2,
    K_SLASH  = 5'd3,
    K_ASSIGN = 5'd4,
    K_EQEQ   = 5'd5,
    K_LT     = 5'd6,
    K_LE     = 5'd7,
    K_GT     = 5'd8,
    K_GE     = 5'd9,
    K_LBRACE = 5'd10,
    K_RBRACE = 5'd11,
    K_LPAREN = 5'd12,
    K_RPAREN = 5'd13,
    K_COMMA  = 5'd14,
    K_STRING = 5'd15,
    K_INT    = 5'd16,
    K_FLOAT  = 5'd17,
    K_IDENT  = 5'd18,
    K_IF     = 5'd19,
    K_ELSE   = 5'd20,
    K_PRINT  = 5'd21,
    K_THEN   = 5'd22,
    K_WHILE  = 5'd23,
    K_DO     = 5'd24,
    K_NOT    = 5'd25,
    K_AND    = 5'd26,
    K_OR     = 5'd27,
    K_TRUE   = 5'd28,
    K_FALSE  = 5'd29,
    K_END    = 5'd30,
    K_ERROR  = 5'd31
  } kind_e;

  typedef enum logic [3:0] {
    M_IDLE  = 4'd0,
    M_LT    = 4'd1,
    M_GT    = 4'd2,
    M_EQ    = 4'd3,
    M_STR   = 4'd4,
    M_INT   = 4'd5,
    M_FRAC  = 4'd6,
    M_IDENT = 4'd7,
    M_HALT  = 4'd8
  } mode_e;

  typedef struct packed {
    kind_e               kind;
    logic [OutPosW-1:0]  start;
    logic [OutPosW-1:0]  length;
    logic [NumW-1:0]     value;
    logic [FracW-1:0]    frac;
    logic                last;
  } tok_t;

  function automatic logic [NumW-1:0] add_digit(logic [NumW-1:0] acc, logic [3:0] d);
    logic [NumW+3:0] v;
    v = {acc, 3'b000} + {2'b00, acc, 1'b0} + {{NumW{1'b0}}, d};
    add_digit = (v > {4'd0, NumMax}) ? NumMax : v[NumW-1:0];
  endfunction

  // First five characters packed with the first one in the low byte.
  function automatic kind_e kw_kind(logic [PrefixW-1:0] p, logic fits, logic [2:0] len);
    kind_e k;
    k = K_IDENT;
    if (fits) begin
      case (len)
        3'd2: begin
          if (p == {24'd0, "fi"}) k = K_IF;
          else if (p == {24'd0, "od"}) k = K_DO;
          else if (p == {24'd0, "ro"}) k = K_OR;
        end
        3'd3: begin
          if (p == {16'd0, "ton"}) k = K_NOT;
          else if (p == {16'd0, "dna"}) k = K_AND;
        end
        3'd4: begin
          if (p == {8'd0, "esle"}) k = K_ELSE;
          else if (p == {8'd0, "neht"}) k = K_THEN;
          else if (p == {8'd0, "eurt"}) k = K_TRUE;
        end
        3'd5: begin
          if (p == "tnirp") k = K_PRINT;
          else if (p == "elihw") k = K_WHILE;
          else if (p == "eslaf") k = K_FALSE;
        end
        default: k = K_IDENT;
      endcase
    end
    kw_kind = k;
  endfunction

endpackage

// File: rtl/keyword_lexer_core.sv
// Character-serial lexer. One source byte is taken per beat on the input
// channel (byte 0 ends the stream) and tokens leave on the output channel.
// Each byte is lexed combinationally against the mode registers, and its
// zero, one or two tokens go into a three-entry result queue, so a token is
// offered on the output from the registered queue. The input is ready
// while the queue holds at most one token: with the output side taking one
// token per cycle a byte is accepted every cycle, and a byte that gives two
// tokens stalls the input until the queue holds one token again.
// After an invalid byte the block emits an error token, keeps accepting
// bytes but gives no further tokens until reset.
module keyword_lexer_core #(
  parameter int POSITION_BITS = kwlex_pkg::PosBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  ch_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  kind_o,
  output logic [15:0] token_start_o,
  output logic [15:0] token_length_o,
  output logic [30:0] number_value_o,
  output logic [4:0]  fraction_digits_o,
  output logic        last_of_run_o
);
  import kwlex_pkg::*;

  localparam int P    = POSITION_BITS;
  localparam int ExtW = (P > OutPosW) ? P : OutPosW;
  localparam logic [P-1:0] PosOne = P'(1);

  mode_e               mode_q, mode_d;
  logic [P-1:0]        start_q, start_d;
  logic [P-1:0]        pos_q, pos_d;
  logic [P-1:0]        run_q, run_d;
  logic [NumW-1:0]     acc_q, acc_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic [PrefixW-1:0]  prefix_q, prefix_d;

  tok_t       mem_q [3];
  logic [1:0] wr_q, rd_q, cnt_q;
  logic [1:0] wr_d, rd_d, cnt_d;

  logic [7:0]      c;
  logic            is_digit, is_alpha, is_word;
  logic [NumW-1:0] acc_add;
  logic            emit0, emit1, run_idle;
  tok_t            tok0, tok1, slot_a, slot_b;
  logic [1:0]      n_push;
  logic            accept, pop;
  kind_e           word_kind;

  function automatic logic [OutPosW-1:0] out_pos(logic [P-1:0] v);
    logic [ExtW-1:0] e;
    e = ExtW'(v);
    out_pos = e[OutPosW-1:0];
  endfunction

  function automatic tok_t mk_tok(kind_e k, logic [P-1:0] s, logic [P-1:0] l,
                                  logic [NumW-1:0] v, logic [FracW-1:0] f);
    tok_t t;
    t.kind   = k;
    t.start  = out_pos(s);
    t.length = out_pos(l);
    t.value  = v;
    t.frac   = f;
    t.last   = 1'b0;
    mk_tok = t;
  endfunction

  function automatic logic [1:0] ptr_inc(logic [1:0] p);
    ptr_inc = (p == 2'd2) ? 2'd0 : p + 2'd1;
  endfunction

  assign c        = ch_i;
  assign is_digit = c inside {["0":"9"]};
  assign is_alpha = c inside {["a":"z"], ["A":"Z"]};
  assign is_word  = is_alpha || is_digit || (c == "_");
  assign acc_add  = add_digit(acc_q, c[3:0]);
  assign word_kind = kw_kind(prefix_q, run_q <= P'(5), run_q[2:0]);

  assign in_ready_o = (cnt_q <= 2'd1);
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop        = out_valid_o && out_ready_i;

  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q + PosOne;
    run_d    = run_q;
    acc_d    = acc_q;
    frac_d   = frac_q;
    prefix_d = prefix_q;
    emit0    = 1'b0;
    emit1    = 1'b0;
    run_idle = 1'b0;
    tok0     = mk_tok(K_IDENT, start_q, '0, '0, '0);
    tok1     = mk_tok(K_END, pos_q, '0, '0, '0);

    case (mode_q)
      M_LT, M_GT, M_EQ: begin
        emit0 = 1'b1;
        if (c == "=") begin
          mode_d = M_IDLE;
          case (mode_q)
            M_LT:    tok0.kind = K_LE;
            M_GT:    tok0.kind = K_GE;
            default: tok0.kind = K_EQEQ;
          endcase
        end else begin
          run_idle = 1'b1;
          case (mode_q)
            M_LT:    tok0.kind = K_LT;
            M_GT:    tok0.kind = K_GT;
            default: tok0.kind = K_ASSIGN;
          endcase
        end
      end
      M_STR: begin
        if (c == "\"") begin
          emit0  = 1'b1;
          tok0   = mk_tok(K_STRING, start_q, run_q, '0, '0);
          mode_d = M_IDLE;
        end else if (c == 8'd0) begin
          emit0    = 1'b1;
          tok0     = mk_tok(K_STRING, start_q, run_q, '0, '0);
          run_idle = 1'b1;
        end else if (run_q != '1) begin
          run_d = run_q + PosOne;
        end
      end
      M_INT: begin
        if (is_digit) begin
          acc_d = acc_add;
        end else if (c == ".") begin
          mode_d = M_FRAC;
        end else begin
          emit0    = 1'b1;
          tok0     = mk_tok(K_INT, start_q, '0, acc_q, '0);
          run_idle = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit) begin
          acc_d = acc_add;
          if (frac_q != FracMax) frac_d = frac_q + FracW'(1);
        end else begin
          emit0    = 1'b1;
          tok0     = mk_tok(K_FLOAT, start_q, '0, acc_q, frac_q);
          run_idle = 1'b1;
        end
      end
      M_IDENT: begin
        if (is_word) begin
          if (run_q < P'(5)) prefix_d[{run_q[2:0], 3'b000} +: 8] = c;
          if (run_q != '1) run_d = run_q + PosOne;
        end else begin
          emit0    = 1'b1;
          tok0     = mk_tok(word_kind, start_q, run_q, '0, '0);
          run_idle = 1'b1;
        end
      end
      M_HALT: begin
        pos_d = pos_q;
      end
      default: run_idle = 1'b1;
    endcase

    if (run_idle) begin
      mode_d = M_IDLE;
      case (c)
        " ", "\t", "\n": ;
        "+": begin emit1 = 1'b1; tok1.kind = K_PLUS;   end
        "-": begin emit1 = 1'b1; tok1.kind = K_MINUS;  end
        "*": begin emit1 = 1'b1; tok1.kind = K_STAR;   end
        "/": begin emit1 = 1'b1; tok1.kind = K_SLASH;  end
        "{": begin emit1 = 1'b1; tok1.kind = K_LBRACE; end
        "}": begin emit1 = 1'b1; tok1.kind = K_RBRACE; end
        "(": begin emit1 = 1'b1; tok1.kind = K_LPAREN; end
        ")": begin emit1 = 1'b1; tok1.kind = K_RPAREN; end
        ",": begin emit1 = 1'b1; tok1.kind = K_COMMA;  end
        "<": begin mode_d = M_LT; start_d = pos_q; end
        ">": begin mode_d = M_GT; start_d = pos_q; end
        "=": begin mode_d = M_EQ; start_d = pos_q; end
        "\"": begin
          mode_d  = M_STR;
          start_d = pos_q + PosOne;
          run_d   = '0;
        end
        8'd0: begin
          emit1    = 1'b1;
          tok1.kind = K_END;
          mode_d   = M_IDLE;
          start_d  = '0;
          pos_d    = '0;
          run_d    = '0;
          acc_d    = '0;
          frac_d   = '0;
          prefix_d = '0;
        end
        default: begin
          if (is_digit) begin
            mode_d  = M_INT;
            start_d = pos_q;
            acc_d   = NumW'(c[3:0]);
            frac_d  = '0;
          end else if (is_alpha) begin
            mode_d   = M_IDENT;
            start_d  = pos_q;
            run_d    = PosOne;
            prefix_d = PrefixW'(c);
          end else begin
            emit1     = 1'b1;
            tok1.kind = K_ERROR;
            mode_d    = M_HALT;
          end
        end
      endcase
    end

    slot_b      = tok1;
    slot_b.last = 1'b1;
    if (emit0) begin
      slot_a      = tok0;
      slot_a.last = !emit1;
    end else begin
      slot_a = slot_b;
    end
    n_push = accept ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
  end

  always_comb begin
    case (n_push)
      2'd0:    wr_d = wr_q;
      2'd1:    wr_d = ptr_inc(wr_q);
      default: wr_d = ptr_inc(ptr_inc(wr_q));
    endcase
    rd_d  = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + n_push - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      start_q  <= '0;
      pos_q    <= '0;
      run_q    <= '0;
      acc_q    <= '0;
      frac_q   <= '0;
      prefix_q <= '0;
      wr_q     <= '0;
      rd_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (accept) begin
        mode_q   <= mode_d;
        start_q  <= start_d;
        pos_q    <= pos_d;
        run_q    <= run_d;
        acc_q    <= acc_d;
        frac_q   <= frac_d;
        prefix_q <= prefix_d;
      end
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) mem_q[wr_q] <= slot_a;
    if (n_push == 2'd2) mem_q[ptr_inc(wr_q)] <= slot_b;
  end

  tok_t head;
  assign head              = mem_q[rd_q];
  assign kind_o            = head.kind;
  assign token_start_o     = head.start;
  assign token_length_o    = head.length;
  assign number_value_o    = head.value;
  assign fraction_digits_o = head.frac;
  assign last_of_run_o     = head.last;

endmodule

// File: rtl/kwlex_checker.sv
module kwlex_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [4:0]  kind_o,
  input logic [15:0] token_length_o,
  input logic [4:0]  fraction_digits_o,
  input logic        last_of_run_o
);
  import kwlex_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == K_END || kind_o == K_ERROR) |-> last_of_run_o)
    else $error("end or error token not last of its byte");

  a_len_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_length_o != 16'd0 |->
      (kind_o == K_STRING || (kind_o >= K_IDENT && kind_o <= K_FALSE)))
    else $error("length on a token without text");

  a_frac_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fraction_digits_o != 5'd0 |-> kind_o == K_FLOAT)
    else $error("fraction digits on a non-float token");

endmodule

bind keyword_lexer_core kwlex_checker u_kwlex_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .kind_o            (kind_o),
  .token_length_o    (token_length_o),
  .fraction_digits_o (fraction_digits_o),
  .last_of_run_o     (last_of_run_o)
);
